// File: rtl/core/e2e7_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and crc-64 helpers for the e2e profile 7 engine
package e2e7_pkg;

    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(20);
    localparam logic [POS_W-1:0] OFS_LENGTH  = POS_W'(8);
    localparam logic [POS_W-1:0] OFS_COUNTER = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_ID      = POS_W'(16);
    localparam logic [POS_W-1:0] MAX_POS     = POS_W'(MAX_LEN);

    localparam logic [63:0] CRC_POLY_REFL = 64'hC96C_5795_D787_0F42;
    localparam logic [63:0] ALL_ONES64    = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INCR_ENABLE   = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [12:0] msg_length;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] crc_value;
        logic [31:0] counter_value;
        logic        check_ok;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] data_id;
        logic [11:0] header_offset;
        logic        protect_mode;
        logic        increment_enable;
    } t_cfg;

    // reflected crc-64 update over one byte
    function automatic logic [63:0] crc_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // big-endian byte k of a 32-bit word
    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // crc over the four bytes of a word, each byte only where its mask bit is set
    function automatic logic [63:0] crc_word_masked(input logic [63:0] crc,
                                                    input logic [31:0] w,
                                                    input logic [3:0]  mask);
        logic [63:0] c;
        c = crc;
        for (int k = 0; k < 4; k++) begin
            if (mask[k]) begin
                c = crc_byte(c, byte_of(w, 2'(k)));
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/e2e_profile7_protect_check.sv
`timescale 1ns / 1ps
// e2e profile 7 protect/check engine, top level with request and result registers
// result path: the last byte goes from the input register through the crc update into the result register on o_out_data
// throughput: one byte per cycle while a last byte finds room in the result register, set by the byte-wide crc-64
// update between the input register and the message state registers
// reset: synchronous, active low; clears message state, the valid flags of both registers and the
// configuration to its defaults (increment enabled, all else zero)
module e2e_profile7_protect_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  e2e7_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output e2e7_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [e2e7_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [e2e7_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import e2e7_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      out_free;
    logic      proc_take;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    e2e7_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    e2e7_msg_proc u_msg_proc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_take   (proc_take),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // only the last byte needs room in the result register
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc_take  = r_in_valid && (!r_in_item.last || out_free);
    assign o_in_ready = !r_in_valid || proc_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_take && r_in_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_take && r_in_item.last) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_take && r_in_item.last |=> o_out_valid)
        else $error("last byte did not produce a result");

    a_bad_result_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |->
            (o_out_data.crc_value == '0) && !o_out_data.check_ok &&
            (o_out_data.counter_value == '0))
        else $error("invalid message result carries data");

    a_ok_only_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.check_ok |-> !cfg.protect_mode)
        else $error("check_ok set in protect mode");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result overwritten");
`endif

endmodule

// File: rtl/core/e2e7_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register bank for the e2e profile 7 engine
module e2e7_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [e2e7_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [e2e7_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output e2e7_pkg::t_cfg                  o_cfg
);
    import e2e7_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DATA_ID:       n_cfg.data_id          = i_cfg_wdata;
                CFG_HEADER_OFFSET: n_cfg.header_offset    = i_cfg_wdata[11:0];
                CFG_PROTECT_MODE:  n_cfg.protect_mode     = i_cfg_wdata[0];
                CFG_INCR_ENABLE:   n_cfg.increment_enable = i_cfg_wdata[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_id          <= '0;
            r_cfg.header_offset    <= '0;
            r_cfg.protect_mode     <= 1'b0;
            r_cfg.increment_enable <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/e2e7_msg_proc.sv
`timescale 1ns / 1ps
// per-byte message state: header capture, crc update and result build
module e2e7_msg_proc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  e2e7_pkg::t_cfg      i_cfg,
    input  logic                i_take,
    input  e2e7_pkg::t_in_item  i_item,
    output e2e7_pkg::t_out_item o_result
);
    import e2e7_pkg::*;

    logic [63:0]      r_crc,     n_crc;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [POS_W-1:0] r_len,     n_len;
    logic [31:0]      r_counter, n_counter;
    logic [63:0]      r_rx_crc,  n_rx_crc;
    logic [31:0]      r_rx_len,  n_rx_len;
    logic [31:0]      r_rx_id,   n_rx_id;
    logic             r_overrun, n_overrun;

    logic [POS_W-1:0] off;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] len_eff;
    logic [POS_W-1:0] cnt_base;
    logic [3:0]       cnt_mask;
    logic [7:0]       hash_byte;
    logic [63:0]      crc_out;
    logic             in_hdr;
    logic             prot;
    logic             bad;
    logic             ok;

    always_comb begin
        off      = {1'b0, i_cfg.header_offset};
        prot     = i_cfg.protect_mode;
        len_eff  = (r_pos == '0) ? i_item.msg_length : r_len;
        rel      = r_pos - off;
        in_hdr   = (r_pos >= off) && (rel < HDR_LEN);
        cnt_base = r_pos - POS_W'(3);
        for (int k = 0; k < 4; k++) begin
            cnt_mask[k] = (cnt_base + POS_W'(k)) < len_eff;
        end

        n_crc     = r_crc;
        n_pos     = r_pos;
        n_len     = len_eff;
        n_counter = r_counter;
        n_rx_crc  = r_rx_crc;
        n_rx_len  = r_rx_len;
        n_rx_id   = r_rx_id;
        n_overrun = r_overrun;
        hash_byte = i_item.data_byte;

        if (r_pos < MAX_POS) begin
            n_pos = r_pos + POS_W'(1);
            if (in_hdr && rel < OFS_LENGTH) begin
                n_rx_crc = {r_rx_crc[55:0], i_item.data_byte};
            end else if (in_hdr && rel < OFS_COUNTER) begin
                n_rx_len = {r_rx_len[23:0], i_item.data_byte};
                if (prot) begin
                    hash_byte = byte_of({{(32-POS_W){1'b0}}, len_eff}, rel[1:0]);
                end
                if (r_pos < len_eff) begin
                    n_crc = crc_byte(r_crc, hash_byte);
                end
            end else if (in_hdr && rel < OFS_ID) begin
                n_counter = {r_counter[23:0], i_item.data_byte};
                // counter hashed once settled, only bytes below length
                if (rel[1:0] == 2'd3) begin
                    if (prot && i_cfg.increment_enable) begin
                        n_counter = n_counter + 32'd1;
                    end
                    n_crc = crc_word_masked(r_crc, n_counter, cnt_mask);
                end
            end else if (in_hdr) begin
                n_rx_id = {r_rx_id[23:0], i_item.data_byte};
                if (prot) begin
                    hash_byte = byte_of(i_cfg.data_id, rel[1:0]);
                end
                if (r_pos < len_eff) begin
                    n_crc = crc_byte(r_crc, hash_byte);
                end
            end else if (r_pos < off || r_pos < len_eff) begin
                n_crc = crc_byte(r_crc, hash_byte);
            end
        end else begin
            n_overrun = 1'b1;
        end

        crc_out = n_crc ^ ALL_ONES64;
        bad = n_overrun || (n_pos < HDR_LEN) || (len_eff < HDR_LEN) ||
              (len_eff > n_pos) || (off > (n_pos - HDR_LEN));
        ok  = !prot && (n_rx_len == {{(32-POS_W){1'b0}}, len_eff}) &&
              (n_rx_id == i_cfg.data_id) && (n_rx_crc == crc_out);

        if (bad) begin
            o_result.crc_value     = '0;
            o_result.counter_value = '0;
            o_result.check_ok      = 1'b0;
            o_result.status        = 1'b1;
        end else begin
            o_result.crc_value     = crc_out;
            o_result.counter_value = n_counter;
            o_result.check_ok      = ok;
            o_result.status        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.last)) begin
            r_crc     <= ALL_ONES64;
            r_pos     <= '0;
            r_len     <= '0;
            r_counter <= '0;
            r_rx_crc  <= '0;
            r_rx_len  <= '0;
            r_rx_id   <= '0;
            r_overrun <= 1'b0;
        end else if (i_take) begin
            r_crc     <= n_crc;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_counter <= n_counter;
            r_rx_crc  <= n_rx_crc;
            r_rx_len  <= n_rx_len;
            r_rx_id   <= n_rx_id;
            r_overrun <= n_overrun;
        end
    end

endmodule
